/* rtl/pkvst_pkg.sv */
package pkvst_pkg;

    localparam int MAX_PAIRS = 4096;
    localparam int MAX_SLOTS = 65536;
    localparam int PAIR_W = $clog2(MAX_PAIRS);
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int POS_W = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CFG_STORAGE_NARROW = 3'd0;
    localparam logic [2:0] CFG_HEAD_WIDTH = 3'd1;
    localparam logic [2:0] CFG_PAGE_SIZE_SELECT = 3'd2;
    localparam logic [2:0] CFG_LAYER_COUNT = 3'd3;
    localparam logic [2:0] CFG_HEAD_COUNT = 3'd4;
    localparam logic [2:0] CFG_RING_LEN = 3'd5;
    localparam logic [2:0] CFG_TABLE_CAPACITY = 3'd6;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_BEYOND_TABLE = 3'd2;
    localparam logic [2:0] ST_WRONG_SIZE = 3'd3;
    localparam logic [2:0] ST_PAGE_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_POSITION_LIMIT = 3'd5;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_ACCESS = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [6:0]  layer_index;
        logic [6:0]  head_index;
        logic [23:0] position;
        logic [21:0] byte_count;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] slot_index;
        logic [20:0] byte_offset;
        logic        newly_allocated;
        logic [23:0] used_position;
        logic [23:0] tokens_written;
    } rsp_item_t;

    typedef struct packed {
        logic        storage_narrow;
        logic [10:0] head_width;
        logic [1:0]  page_size_select;
        logic [7:0]  layer_count;
        logic [7:0]  head_count;
        logic [16:0] ring_len;
        logic [16:0] table_capacity;
    } cfg_t;

    typedef struct packed {
        logic              req_type;
        logic              bad_index;
        logic [PAIR_W-1:0] pair;
        logic [23:0]       position;
        logic [21:0]       byte_count;
    } job_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDPOS,
        S_DIV,
        S_MUL,
        S_CHECK,
        S_RDPRES
    } back_state_t;

endpackage

/* rtl/pkvst_ram.sv */
module pkvst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/pkvst_front.sv */
module pkvst_front
    import pkvst_pkg::*;
(
    input  logic      req_valid,
    input  req_item_t req,
    output logic      req_stall,
    input  cfg_t      cfg,
    input  logic      q_full,
    input  logic      busy,
    output logic      q_push,
    output job_t      q_job
);

    logic [14:0] pair_full;
    logic        range_bad;

    always_comb
    begin
        pair_full = 15'(req.layer_index) * 15'(cfg.head_count) + 15'(req.head_index);
        range_bad = ({1'b0, req.layer_index} >= cfg.layer_count)
                 || ({1'b0, req.head_index} >= cfg.head_count)
                 || (pair_full >= 15'(MAX_PAIRS));
        req_stall = q_full || busy;
        q_push = req_valid && !req_stall;
        q_job.req_type = req.req_type;
        q_job.bad_index = range_bad;
        q_job.pair = pair_full[PAIR_W-1:0];
        q_job.position = req.position;
        q_job.byte_count = req.byte_count;
    end

endmodule

/* rtl/pkvst_queue.sv */
module pkvst_queue
    import pkvst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic q_valid,
    output logic q_full,
    output job_t head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    always_comb
    begin
        q_valid = (count_reg != '0);
        q_full = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
        head_job = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/pkvst_back.sv */
module pkvst_back
    import pkvst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  job_t      head_job,
    output logic      q_pop,
    output logic      busy,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    back_state_t       state_reg, state_next;
    job_t              job_reg, job_next;
    logic [23:0]       pos_reg, pos_next;
    logic [11:0]       bpt_reg, bpt_next;
    logic [16:0]       rem_reg, rem_next;
    logic [15:0]       pn_reg, pn_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [29:0]       slot_reg, slot_next;
    logic [21:0]       ofs_reg, ofs_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [23:0]       last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    rsp_item_t         out_reg, out_next;

    logic              pos_we, pres_we;
    logic [PAIR_W-1:0] pos_waddr, pos_raddr;
    logic [23:0]       pos_wdata, pos_rdata;
    logic [SLOT_W-1:0] pres_waddr, pres_raddr;
    logic              pres_wdata;
    logic [0:0]        pres_rdata;

    logic [3:0]  shift;
    logic [16:0] rp;
    logic [11:0] bpt;
    logic [23:0] cur_pos;
    logic [17:0] div_tmp;
    logic [9:0]  in_page;
    logic [22:0] page_bytes;
    logic        fresh;

    pkvst_ram #(.WIDTH(24), .DEPTH(MAX_PAIRS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    pkvst_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_pres_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (pres_raddr),
        .rdata (pres_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg && !head_job.bad_index)
                begin
                    state_next = S_RDPOS;
                end
            end
            S_RDPOS:
            begin
                if (job_reg.req_type == REQ_APPEND
                    && (job_reg.byte_count != 22'(bpt) || pos_rdata == '1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (slot_reg >= 30'(cfg.table_capacity) || slot_reg >= 30'(MAX_SLOTS))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RDPRES;
                end
            end
            S_RDPRES:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (cfg.page_size_select)
            2'd0: shift = 4'd8;
            2'd1: shift = 4'd9;
            default: shift = 4'd10;
        endcase
        rp = (cfg.ring_len == '0) ? 17'd1 : cfg.ring_len;
        bpt = cfg.storage_narrow ? {1'b0, cfg.head_width} : {cfg.head_width, 1'b0};
        cur_pos = (job_reg.req_type == REQ_APPEND) ? pos_rdata : job_reg.position;
        div_tmp = {rem_reg, pn_reg[15]};
        if (div_tmp >= {1'b0, rp})
        begin
            div_tmp = div_tmp - {1'b0, rp};
        end
        in_page = 10'(pos_reg & ((24'd1 << shift) - 24'd1));
        page_bytes = 23'(bpt_reg) << shift;
        fresh = (rem_reg != '0) && !pres_rdata[0];

        q_pop = 1'b0;
        busy = (state_reg == S_CLEAR);
        job_next = job_reg;
        pos_next = pos_reg;
        bpt_next = bpt_reg;
        rem_next = rem_reg;
        pn_next = pn_reg;
        cnt_next = cnt_reg;
        slot_next = slot_reg;
        ofs_next = ofs_reg;
        clr_next = clr_reg;
        last_next = last_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next = out_reg;
        pos_we = 1'b0;
        pos_waddr = job_reg.pair;
        pos_wdata = 24'(pos_reg + 24'd1);
        pos_raddr = head_job.pair;
        pres_we = 1'b0;
        pres_waddr = slot_reg[SLOT_W-1:0];
        pres_wdata = 1'b1;
        pres_raddr = slot_reg[SLOT_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = SLOT_W'(clr_reg + 1'b1);
                pres_we = 1'b1;
                pres_waddr = clr_reg;
                pres_wdata = 1'b0;
                pos_we = (32'(clr_reg) < MAX_PAIRS);
                pos_waddr = clr_reg[PAIR_W-1:0];
                pos_wdata = '0;
            end
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    job_next = head_job;
                    if (head_job.bad_index)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '0;
                        out_next.status = ST_BAD_INDEX;
                        out_next.tokens_written = last_reg;
                    end
                end
            end
            S_RDPOS:
            begin
                bpt_next = bpt;
                pos_next = cur_pos;
                pn_next = 16'(cur_pos >> shift);
                rem_next = '0;
                cnt_next = '0;
                out_next = '0;
                out_next.tokens_written = last_reg;
                if (job_reg.req_type == REQ_APPEND && job_reg.byte_count != 22'(bpt))
                begin
                    out_valid_next = 1'b1;
                    out_next.status = ST_WRONG_SIZE;
                end
                else if (job_reg.req_type == REQ_APPEND && pos_rdata == '1)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = ST_POSITION_LIMIT;
                end
            end
            S_DIV:
            begin
                rem_next = div_tmp[16:0];
                pn_next = {pn_reg[14:0], 1'b0};
                cnt_next = 4'(cnt_reg + 1'b1);
            end
            S_MUL:
            begin
                slot_next = 30'(job_reg.pair) * 30'(rp) + 30'(rem_reg);
                ofs_next = 22'(in_page) * 22'(bpt_reg);
            end
            S_CHECK:
            begin
                if (slot_reg >= 30'(cfg.table_capacity) || slot_reg >= 30'(MAX_SLOTS))
                begin
                    out_valid_next = 1'b1;
                    out_next.status = ST_BEYOND_TABLE;
                    out_next.used_position = pos_reg;
                end
            end
            S_RDPRES:
            begin
                pres_we = fresh;
                out_valid_next = 1'b1;
                out_next.status = ST_OK;
                out_next.slot_index = slot_reg[SLOT_W-1:0];
                out_next.byte_offset = ofs_reg[20:0];
                out_next.newly_allocated = fresh;
                out_next.used_position = pos_reg;
                if (job_reg.req_type == REQ_APPEND)
                begin
                    pos_we = 1'b1;
                    last_next = 24'(pos_reg + 24'd1);
                    out_next.tokens_written = 24'(pos_reg + 24'd1);
                end
                else if ((23'(ofs_reg) + 23'(job_reg.byte_count)) > page_bytes)
                begin
                    out_next.status = ST_PAGE_OVERFLOW;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        pos_reg <= pos_next;
        bpt_reg <= bpt_next;
        rem_reg <= rem_next;
        pn_reg <= pn_next;
        cnt_reg <= cnt_next;
        slot_reg <= slot_next;
        ofs_reg <= ofs_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            last_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            last_reg <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

/* rtl/paged_kv_slot_translator_unit.sv */
// A request whose pair index is out of range yields its bad-index item straight from idle.
// An append refused for size or position limit yields it after the position read, a request
// beyond the table after the slot check, and any other request after the 16-step remainder
// loop, the multiply and the presence read. The back end works one item at a time and takes
// the next one the cycle after its result leaves; a 2-entry queue lets the front accept.
// After reset a clearing pass sweeps both memories; no request is accepted then.
module paged_kv_slot_translator_unit
    import pkvst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_item_t   req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_item_t   rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_pop, q_valid, q_full, busy;
    job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STORAGE_NARROW: cfg_next.storage_narrow = cfg_data[0];
                CFG_HEAD_WIDTH: cfg_next.head_width = cfg_data[10:0];
                CFG_PAGE_SIZE_SELECT: cfg_next.page_size_select = cfg_data[1:0];
                CFG_LAYER_COUNT: cfg_next.layer_count = cfg_data[7:0];
                CFG_HEAD_COUNT: cfg_next.head_count = cfg_data[7:0];
                CFG_RING_LEN: cfg_next.ring_len = cfg_data[16:0];
                CFG_TABLE_CAPACITY: cfg_next.table_capacity = cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.storage_narrow <= 1'b0;
            cfg_reg.head_width <= 11'd128;
            cfg_reg.page_size_select <= 2'd1;
            cfg_reg.layer_count <= 8'd1;
            cfg_reg.head_count <= 8'd1;
            cfg_reg.ring_len <= 17'd4;
            cfg_reg.table_capacity <= 17'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pkvst_front u_front (
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .busy      (busy),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    pkvst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head_job (head_job)
    );

    pkvst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .head_job  (head_job),
        .q_pop     (q_pop),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("Queue written while full.");

    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !q_push && !q_pop)
        else $error("Request moved during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_BAD_INDEX |-> rsp.slot_index == '0
            && rsp.used_position == '0 && !rsp.newly_allocated)
        else $error("Bad-index item carries translation fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.newly_allocated |->
            rsp.status == ST_OK || rsp.status == ST_PAGE_OVERFLOW)
        else $error("Page flagged new on a refused request.");

endmodule
